// ===== hdl/ksc_pkg.sv =====
`timescale 1ns / 1ps

package ksc_pkg;

  localparam int unsigned DaedLen   = 4;
  localparam int unsigned RoadLen   = 4;
  localparam int unsigned CobbleLen = 6;
  localparam int unsigned PathLen   = 4;

  // Index 0 holds the first letter of each keyword
  localparam logic [DaedLen-1:0][7:0]   KW_DAED   = "dead";
  localparam logic [RoadLen-1:0][7:0]   KW_ROAD   = "daor";
  localparam logic [CobbleLen-1:0][7:0] KW_COBBLE = "elbboc";
  localparam logic [PathLen-1:0][7:0]   KW_PATH   = "htap";

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
  localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       name_end;
  } item_t;

  typedef struct packed {
    logic accepted;
    logic saw_exclusion;
    logic saw_road;
    logic saw_cobble;
    logic saw_path;
  } verdict_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r = c + ASCII_CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== hdl/ksc_in_if.sv =====
`timescale 1ns / 1ps

interface ksc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       name_end;

  modport source (output valid, output text_byte, output byte_present, output name_end,
                  input ready);
  modport sink (input valid, input text_byte, input byte_present, input name_end,
                output ready);
endinterface

// ===== hdl/ksc_out_if.sv =====
`timescale 1ns / 1ps

interface ksc_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic saw_exclusion;
  logic saw_road;
  logic saw_cobble;
  logic saw_path;

  modport source (output valid, output accepted, output saw_exclusion, output saw_road,
                  output saw_cobble, output saw_path, input ready);
  modport sink (input valid, input accepted, input saw_exclusion, input saw_road,
                input saw_cobble, input saw_path, output ready);
endinterface

// ===== hdl/ksc_kw_track.sv =====
`timescale 1ns / 1ps

module ksc_kw_track #(
  parameter int unsigned KwLen = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  clear_i,
  input  logic [7:0]            byte_i,
  input  logic [KwLen-1:0][7:0] kw_i,
  output logic                  found_o,
  output logic                  seen_o
);

  logic [KwLen-2:0] pre_q, pre_d;
  logic             seen_q, seen_d;
  logic [KwLen-1:0] cand;
  logic [KwLen-1:0] hit_vec;

  always_comb begin
    cand = {pre_q, 1'b1};
    for (int i = 0; i < KwLen; i++) begin
      hit_vec[i] = cand[i] && (byte_i == kw_i[i]);
    end
  end

  assign found_o = seen_q | (step_i & hit_vec[KwLen-1]);
  assign seen_o  = seen_q;

  always_comb begin
    pre_d  = pre_q;
    seen_d = seen_q;
    if (clear_i) begin
      pre_d  = '0;
      seen_d = 1'b0;
    end else if (step_i) begin
      pre_d  = hit_vec[KwLen-2:0];
      seen_d = found_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      pre_q  <= pre_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== hdl/keyword_substring_classifier.sv =====
`timescale 1ns / 1ps
// A name-end beat enters the input register; its verdict is then registered into
// the result register, which drives the output. Throughput: one beat per cycle; the
// input register and the result register let a new beat enter while a verdict waits
// on the output. A name-end beat holds in the input register only while the verdict ahead of it is not taken.
// Reset: asynchronous active-low clears both valid flags, all keyword prefix
// vectors and the found flags; payload registers are not reset.

module keyword_substring_classifier (
  input  logic clk_i,
  input  logic rst_ni,
  ksc_in_if.sink    text_i,
  ksc_out_if.source verdict_o
);

  import ksc_pkg::*;

  item_t    s1_q;
  logic     s1_valid_q, s1_valid_d;
  verdict_t res_q, res_d;
  logic     out_valid_q, out_valid_d;

  logic       in_fire;
  logic       s1_adv;
  logic       step;
  logic       clear;
  logic [7:0] folded;
  logic [3:0] found;
  logic [3:0] seen;

  assign s1_adv  = s1_valid_q && (!s1_q.name_end || !out_valid_q || verdict_o.ready);
  assign text_i.ready = !s1_valid_q || s1_adv;
  assign in_fire = text_i.valid && text_i.ready;

  assign step   = s1_adv && s1_q.byte_present;
  assign clear  = s1_adv && s1_q.name_end;
  assign folded = fold_lower(s1_q.text_byte);

  ksc_kw_track #(.KwLen(DaedLen)) u_daed (
    .clk_i, .rst_ni, .step_i(step), .clear_i(clear), .byte_i(folded),
    .kw_i(KW_DAED), .found_o(found[0]), .seen_o(seen[0])
  );

  ksc_kw_track #(.KwLen(RoadLen)) u_road (
    .clk_i, .rst_ni, .step_i(step), .clear_i(clear), .byte_i(folded),
    .kw_i(KW_ROAD), .found_o(found[1]), .seen_o(seen[1])
  );

  ksc_kw_track #(.KwLen(CobbleLen)) u_cobble (
    .clk_i, .rst_ni, .step_i(step), .clear_i(clear), .byte_i(folded),
    .kw_i(KW_COBBLE), .found_o(found[2]), .seen_o(seen[2])
  );

  ksc_kw_track #(.KwLen(PathLen)) u_path (
    .clk_i, .rst_ni, .step_i(step), .clear_i(clear), .byte_i(folded),
    .kw_i(KW_PATH), .found_o(found[3]), .seen_o(seen[3])
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_d.accepted      = !found[0] && (found[1] || found[2] || found[3]);
    res_d.saw_exclusion = found[0];
    res_d.saw_road      = found[1];
    res_d.saw_cobble    = found[2];
    res_d.saw_path      = found[3];
    out_valid_d = out_valid_q;
    if (clear) begin
      out_valid_d = 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.text_byte    <= text_i.text_byte;
      s1_q.byte_present <= text_i.byte_present;
      s1_q.name_end     <= text_i.name_end;
    end
    if (clear) begin
      res_q <= res_d;
    end
  end

  assign verdict_o.valid         = out_valid_q;
  assign verdict_o.accepted      = res_q.accepted;
  assign verdict_o.saw_exclusion = res_q.saw_exclusion;
  assign verdict_o.saw_road      = res_q.saw_road;
  assign verdict_o.saw_cobble    = res_q.saw_cobble;
  assign verdict_o.saw_path      = res_q.saw_path;

  a_clear_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (seen == 4'b0000))
    else $error("found flags not cleared after name end");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_i.ready |-> (s1_valid_q && s1_q.name_end && out_valid_q && !verdict_o.ready))
    else $error("input stalled without a blocked verdict");

  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_q.name_end))
    else $error("verdict raised without a name end");

endmodule

// ===== dv/verdict_checker.sv =====
`timescale 1ns / 1ps

module verdict_checker
  import ksc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ksc_in_if    text_mon,
  ksc_out_if   verdict_mon,
  output int   fail_count_o,
  output int   pending_o
);

  logic [DaedLen-2:0]   daed_run;
  logic [RoadLen-2:0]   road_run;
  logic [CobbleLen-2:0] cobble_run;
  logic [PathLen-2:0]   path_run;
  logic [3:0]           seen_words;
  logic [CobbleLen-1:0] step_bits;
  logic [7:0]           lower_byte;
  verdict_t             due_buf [64];
  logic [5:0]           due_head = '0;
  logic [5:0]           due_tail = '0;
  verdict_t             got_verdict;
  verdict_t             want_verdict;
  int                   mismatches = 0;
  int                   due_count = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_count;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      return c + ASCII_CASE_OFFSET;
    end
    return c;
  endfunction

  // bit i of the result: the last i+1 bytes spell the first i+1 letters of kw
  function automatic logic [CobbleLen-1:0] match_step(input logic [CobbleLen-2:0] prev,
                                                      input logic [CobbleLen-1:0][7:0] kw,
                                                      input int unsigned len,
                                                      input logic [7:0] c);
    logic [CobbleLen-1:0] cand;
    logic [CobbleLen-1:0] nxt;
    int unsigned          i;
    cand = {prev, 1'b1};
    nxt  = '0;
    for (i = 0; i < len; i++) begin
      if (cand[i] && c == kw[i]) begin
        nxt[i] = 1'b1;
      end
    end
    return nxt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      daed_run   = '0;
      road_run   = '0;
      cobble_run = '0;
      path_run   = '0;
      seen_words = '0;
    end else begin
      if (verdict_mon.valid && verdict_mon.ready) begin
        got_verdict = {verdict_mon.accepted, verdict_mon.saw_exclusion, verdict_mon.saw_road,
                       verdict_mon.saw_cobble, verdict_mon.saw_path};
        if (due_count == 0) begin
          mismatches++;
          $display("%0t unexpected verdict beat: expected none, got %b", $time, got_verdict);
        end else begin
          want_verdict = due_buf[due_head];
          due_head++;
          due_count--;
          if (got_verdict !== want_verdict) begin
            mismatches++;
            $display("%0t verdict mismatch (accepted exclusion road cobble path): ",
                     $time, "expected %b %b %b %b %b, got %b %b %b %b %b",
                     want_verdict.accepted, want_verdict.saw_exclusion, want_verdict.saw_road,
                     want_verdict.saw_cobble, want_verdict.saw_path,
                     got_verdict.accepted, got_verdict.saw_exclusion, got_verdict.saw_road,
                     got_verdict.saw_cobble, got_verdict.saw_path);
          end
        end
      end
      if (text_mon.valid && text_mon.ready) begin
        if (text_mon.byte_present) begin
          lower_byte = to_lower(text_mon.text_byte);
          step_bits = match_step({{(CobbleLen-DaedLen){1'b0}}, daed_run},
                                 {{(CobbleLen-DaedLen){8'h00}}, KW_DAED}, DaedLen, lower_byte);
          daed_run = step_bits[DaedLen-2:0];
          seen_words[0] |= step_bits[DaedLen-1];
          step_bits = match_step({{(CobbleLen-RoadLen){1'b0}}, road_run},
                                 {{(CobbleLen-RoadLen){8'h00}}, KW_ROAD}, RoadLen, lower_byte);
          road_run = step_bits[RoadLen-2:0];
          seen_words[1] |= step_bits[RoadLen-1];
          step_bits = match_step(cobble_run, KW_COBBLE, CobbleLen, lower_byte);
          cobble_run = step_bits[CobbleLen-2:0];
          seen_words[2] |= step_bits[CobbleLen-1];
          step_bits = match_step({{(CobbleLen-PathLen){1'b0}}, path_run},
                                 {{(CobbleLen-PathLen){8'h00}}, KW_PATH}, PathLen, lower_byte);
          path_run = step_bits[PathLen-2:0];
          seen_words[3] |= step_bits[PathLen-1];
        end
        if (text_mon.name_end) begin
          want_verdict.accepted      = !seen_words[0] && (seen_words[3:1] != '0);
          want_verdict.saw_exclusion = seen_words[0];
          want_verdict.saw_road      = seen_words[1];
          want_verdict.saw_cobble    = seen_words[2];
          want_verdict.saw_path      = seen_words[3];
          due_buf[due_tail] = want_verdict;
          due_tail++;
          due_count++;
          daed_run   = '0;
          road_run   = '0;
          cobble_run = '0;
          path_run   = '0;
          seen_words = '0;
        end
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;
  bit   paused;
  int   items_sent;
  int   sink_hold = 0;
  int   chk_fails;
  int   chk_due;

  ksc_in_if  text_if ();
  ksc_out_if verdict_if ();

  keyword_substring_classifier dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .text_i    (text_if),
    .verdict_o (verdict_if)
  );

  verdict_checker u_verdict_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_mon     (text_if),
    .verdict_mon  (verdict_if),
    .fail_count_o (chk_fails),
    .pending_o    (chk_due)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      verdict_if.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      verdict_if.ready <= 1'b0;
      sink_hold <= $urandom_range(0, 16);
    end else begin
      verdict_if.ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
    logic took;
    if (!calm && $urandom_range(0, 5) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    text_if.valid        <= 1'b1;
    text_if.text_byte    <= b;
    text_if.byte_present <= present;
    text_if.name_end     <= last;
    do begin
      @(negedge clk_i);
      took = text_if.ready;
      @(posedge clk_i);
    end while (!took);
    if (present || last) begin
      items_sent++;
    end
  endtask

  task automatic send_name(input string s, input bit bare_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b1, !bare_end && i == s.len() - 1);
    end
    if (bare_end || s.len() == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic wait_verdicts_done();
    int guard;
    guard = 0;
    text_if.valid <= 1'b0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (chk_due != 0 && guard < 20000);
    @(posedge clk_i);
  endtask

  function automatic string word_piece(input int k);
    case (k)
      0:       return "daed";
      1:       return "road";
      2:       return "cobble";
      3:       return "path";
      4:       return "dae";
      5:       return "roa";
      6:       return "cobbl";
      7:       return "pat";
      8:       return "ddaed";
      9:       return "rroad";
      10:      return "cobcobble";
      default: return "papath";
    endcase
  endfunction

  task automatic send_random_name();
    logic [7:0] chars [64];
    logic [5:0] n_chars;
    logic [5:0] k;
    string      piece;
    string      pool;
    logic [7:0] c;
    int         parts;
    int         p;
    int         i;
    int         n;
    bit         end_on_byte;
    pool    = "daeroctbhlpx";
    n_chars = '0;
    parts   = $urandom_range(0, 5);
    for (p = 0; p < parts; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          piece = word_piece($urandom_range(0, 11));
          for (i = 0; i < piece.len(); i++) begin
            c = piece[i];
            if ($urandom_range(0, 2) == 0) begin
              c = c - 8'h20;
            end
            chars[n_chars] = c;
            n_chars++;
          end
        end
        5, 6: begin
          chars[n_chars] = pool[$urandom_range(0, pool.len() - 1)];
          n_chars++;
        end
        7: begin
          chars[n_chars] = 8'($urandom_range(0, 255));
          n_chars++;
        end
        8: begin
          if ($urandom_range(0, 1) == 0) begin
            chars[n_chars] = 8'($urandom_range(8'h40, 8'h5b));
          end else begin
            chars[n_chars] = 8'($urandom_range(8'h60, 8'h7b));
          end
          n_chars++;
        end
        default: begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) begin
            chars[n_chars] = pool[$urandom_range(0, pool.len() - 1)];
            n_chars++;
          end
        end
      endcase
    end
    end_on_byte = (n_chars != '0) && ($urandom_range(0, 1) == 1);
    for (k = '0; k < n_chars; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_beat(chars[k], 1'b1, end_on_byte && k == n_chars - 6'd1);
    end
    if (!end_on_byte) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    calm                    = 1'b0;
    paused                  = 1'b0;
    items_sent              = 0;
    text_if.valid           = 1'b0;
    text_if.text_byte       = '0;
    text_if.byte_present    = 1'b0;
    text_if.name_end        = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_name("Road", 1'b0);
    send_name("", 1'b1);
    send_name("cobblE", 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_name("dAEd", 1'b1);
    send_name("@PATH[", 1'b0);
    wait_verdicts_done();

    items_sent = 0;
    while (items_sent < 950) begin
      calm = (items_sent >= 300 && items_sent < 380) || items_sent >= 820;
      if (!paused && items_sent >= 500) begin
        wait_verdicts_done();
        paused = 1'b1;
      end
      send_random_name();
    end

    wait_verdicts_done();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    if (chk_fails == 0 && chk_due == 0) begin
      $display("** keyword_substring_classifier: PASSED **");
    end else begin
      $display("** keyword_substring_classifier: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** keyword_substring_classifier: FAILED **");
    $finish;
  end

endmodule
